// ===== rtl/hcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcm_pkg
// Shared types, constants and the 3x3 majority vote for the HSV color mask
// with binary median filter.
// ----------------------------------------------------------------------------
package hcm_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam int DIV_STEPS = 9;

    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_LATER = 2'd2;
    localparam logic [1:0] PHASE_DRAIN = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] REG_HUE_LOW = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_MIN = 3'd2;
    localparam logic [2:0] REG_VAL_MIN = 3'd3;
    localparam logic [2:0] REG_PALE_SAT_MIN = 3'd4;
    localparam logic [2:0] REG_PALE_VAL_MIN = 3'd5;
    localparam logic [2:0] REG_CHANNEL_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd7;

    localparam logic [7:0] RST_HUE_LOW = 8'd20;
    localparam logic [7:0] RST_HUE_HIGH = 8'd40;
    localparam logic [7:0] RST_SAT_MIN = 8'd100;
    localparam logic [7:0] RST_VAL_MIN = 8'd100;
    localparam logic [7:0] RST_PALE_SAT_MIN = 8'd50;
    localparam logic [7:0] RST_PALE_VAL_MIN = 8'd200;
    localparam logic [7:0] RST_CHANNEL_THRESHOLD = 8'd25;
    localparam logic [10:0] RST_FRAME_WIDTH = 11'd640;

    localparam logic [8:0] HUE_WRAP = 9'd180;

    typedef struct packed {
        logic [7:0]  hue_low;
        logic [7:0]  hue_high;
        logic [7:0]  sat_min;
        logic [7:0]  val_min;
        logic [7:0]  pale_sat_min;
        logic [7:0]  pale_val_min;
        logic [7:0]  channel_threshold;
        logic [10:0] frame_width;
    } cfg_t;

    // At least five of nine per channel; bit t*3+ch of each column.
    function automatic logic [2:0] vote(input logic [8:0] c0, input logic [8:0] c1,
                                        input logic [8:0] c2);
        logic [2:0] res;
        logic [3:0] cnt;
        res = 3'b000;
        for (int ch = 0; ch < 3; ch++)
        begin
            cnt = 4'd0;
            for (int t = 0; t < 3; t++)
            begin
                cnt = cnt + 4'(c0[t*3+ch]) + 4'(c1[t*3+ch]) + 4'(c2[t*3+ch]);
            end
            res[ch] = (cnt >= 4'd5);
        end
        return res;
    endfunction

endpackage

// ===== rtl/hcm_pixel.sv =====
// ----------------------------------------------------------------------------
// hcm_pixel
// BGR to HSV conversion and color mask. Saturation and hue quotients come
// from two restoring dividers that retire one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hcm_pixel
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [7:0]    blue,
    input  logic [7:0]    green,
    input  logic [7:0]    red,
    input  hcm_pkg::cfg_t cfg,
    output logic          done,
    output logic [2:0]    bits
);

    logic [7:0]  v, mn, d;
    logic signed [19:0] n_s;
    logic [17:0] num_h;
    logic [15:0] num_s;

    logic [7:0]  b_reg, g_reg, r_reg, v_reg, d_reg;
    logic [17:0] rem_h_reg, div_h_reg;
    logic [16:0] rem_s_reg, div_s_reg;
    logic [8:0]  q_h_reg, q_s_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;

    logic [8:0]  h;
    logic [7:0]  s;
    logic        pass;

    always_comb
    begin
        v = red;
        if (green > v) v = green;
        if (blue > v) v = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d = v - mn;
        if (v == red)
            n_s = $signed({12'd0, green}) - $signed({12'd0, blue});
        else if (v == green)
            n_s = $signed({12'd0, blue}) - $signed({12'd0, red})
                  + $signed({11'd0, d, 1'b0});
        else
            n_s = $signed({12'd0, red}) - $signed({12'd0, green})
                  + $signed({10'd0, d, 2'b0});
        num_h = 18'(n_s * 20'sd60 + $signed({12'd0, d}) * 20'sd361);
        num_s = 16'(d) * 16'd255 + 16'(v >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 4'(hcm_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            b_reg     <= blue;
            g_reg     <= green;
            r_reg     <= red;
            v_reg     <= v;
            d_reg     <= d;
            rem_h_reg <= num_h;
            div_h_reg <= {1'b0, d, 9'd0};
            rem_s_reg <= {1'b0, num_s};
            div_s_reg <= {1'b0, v, 8'd0};
            q_h_reg   <= 9'd0;
            q_s_reg   <= 9'd0;
        end
        else if (busy_reg)
        begin
            if (rem_h_reg >= div_h_reg)
            begin
                rem_h_reg <= rem_h_reg - div_h_reg;
                q_h_reg   <= {q_h_reg[7:0], 1'b1};
            end
            else
            begin
                q_h_reg <= {q_h_reg[7:0], 1'b0};
            end
            if (rem_s_reg >= div_s_reg)
            begin
                rem_s_reg <= rem_s_reg - div_s_reg;
                q_s_reg   <= {q_s_reg[7:0], 1'b1};
            end
            else
            begin
                q_s_reg <= {q_s_reg[7:0], 1'b0};
            end
            div_h_reg <= div_h_reg >> 1;
            div_s_reg <= div_s_reg >> 1;
        end
    end

    // num_h holds 60*num + 361*d; divisor 2*d.
    always_comb
    begin
        if (d_reg == 8'd0)
            h = 9'd0;
        else if (q_h_reg >= hcm_pkg::HUE_WRAP)
            h = q_h_reg - hcm_pkg::HUE_WRAP;
        else
            h = q_h_reg;
        s = (v_reg == 8'd0) ? 8'd0 : q_s_reg[7:0];
        pass = (h >= {1'b0, cfg.hue_low}) && (h <= {1'b0, cfg.hue_high}) &&
               (((s >= cfg.sat_min) && (v_reg >= cfg.val_min)) ||
                ((s >= cfg.pale_sat_min) && (v_reg >= cfg.pale_val_min)));
        bits = pass ? {r_reg > cfg.channel_threshold, g_reg > cfg.channel_threshold,
                       b_reg > cfg.channel_threshold} : 3'b000;
    end

    assign done = done_reg;

endmodule

// ===== rtl/hsv_color_mask_median_top.sv =====
// ----------------------------------------------------------------------------
// hsv_color_mask_median_top
// HSV color mask with 3x3 binary median filter over a raster pixel stream.
//
//   channel   handshake            payload
//   cfg       psel/penable/pready  paddr, pwdata, prdata
//   in        in_valid/in_ready    opcode, blue, green, red
//   out       out_valid/out_ready  blue_bit, green_bit, red_bit, end_of_frame
//
// Each transaction passes S_IDLE, which accepts it and reads the line store,
// S_CALC, in the bit-serial saturation and hue dividers (nine quotient steps and
// then registered completion), and S_WRITE, which writes back.
// The write-back cycle waits while the output register holds an untaken result.
// Reset clears control state; the line store is not cleared.
// ----------------------------------------------------------------------------
module hsv_color_mask_median_top
#(
    parameter int MAX_WIDTH = hcm_pkg::DEFAULT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        blue_bit,
    output logic        green_bit,
    output logic        red_bit,
    output logic        end_of_frame
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = AW + 1;

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_CALC  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    hcm_pkg::cfg_t cfg_reg;
    logic [2:0] cfg_idx;

    logic [5:0]    line_mem [MAX_WIDTH];
    logic [5:0]    rd_reg;
    logic          mem_we;
    logic [5:0]    mem_wdata;

    logic          op_reg;
    logic [26:0]   window_reg, window_next;
    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    phase_reg, phase_next;
    logic          fc_reg, fc_next;

    logic          out_valid_reg;
    logic [2:0]    out_bits_reg;
    logic          out_eof_reg;
    logic          emit;
    logic [2:0]    emit_bits;
    logic          emit_eof;

    logic          pix_done;
    logic [2:0]    pix_bits;
    logic          in_fire, wr_fire;

    logic [WW-1:0] width_eff, x_inc;
    logic          draining, pending, ignore, last;
    logic [1:0]    phase_w;
    logic [2:0]    p, top, mid, bot;
    logic [8:0]    col, wb, wc;

    assign pready = 1'b1;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low           <= hcm_pkg::RST_HUE_LOW;
            cfg_reg.hue_high          <= hcm_pkg::RST_HUE_HIGH;
            cfg_reg.sat_min           <= hcm_pkg::RST_SAT_MIN;
            cfg_reg.val_min           <= hcm_pkg::RST_VAL_MIN;
            cfg_reg.pale_sat_min      <= hcm_pkg::RST_PALE_SAT_MIN;
            cfg_reg.pale_val_min      <= hcm_pkg::RST_PALE_VAL_MIN;
            cfg_reg.channel_threshold <= hcm_pkg::RST_CHANNEL_THRESHOLD;
            cfg_reg.frame_width       <= hcm_pkg::RST_FRAME_WIDTH;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                hcm_pkg::REG_HUE_LOW:           cfg_reg.hue_low <= pwdata[7:0];
                hcm_pkg::REG_HUE_HIGH:          cfg_reg.hue_high <= pwdata[7:0];
                hcm_pkg::REG_SAT_MIN:           cfg_reg.sat_min <= pwdata[7:0];
                hcm_pkg::REG_VAL_MIN:           cfg_reg.val_min <= pwdata[7:0];
                hcm_pkg::REG_PALE_SAT_MIN:      cfg_reg.pale_sat_min <= pwdata[7:0];
                hcm_pkg::REG_PALE_VAL_MIN:      cfg_reg.pale_val_min <= pwdata[7:0];
                hcm_pkg::REG_CHANNEL_THRESHOLD: cfg_reg.channel_threshold <= pwdata[7:0];
                hcm_pkg::REG_FRAME_WIDTH:       cfg_reg.frame_width <= pwdata[10:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            hcm_pkg::REG_HUE_LOW:           prdata = {24'd0, cfg_reg.hue_low};
            hcm_pkg::REG_HUE_HIGH:          prdata = {24'd0, cfg_reg.hue_high};
            hcm_pkg::REG_SAT_MIN:           prdata = {24'd0, cfg_reg.sat_min};
            hcm_pkg::REG_VAL_MIN:           prdata = {24'd0, cfg_reg.val_min};
            hcm_pkg::REG_PALE_SAT_MIN:      prdata = {24'd0, cfg_reg.pale_sat_min};
            hcm_pkg::REG_PALE_VAL_MIN:      prdata = {24'd0, cfg_reg.pale_val_min};
            hcm_pkg::REG_CHANNEL_THRESHOLD: prdata = {24'd0, cfg_reg.channel_threshold};
            hcm_pkg::REG_FRAME_WIDTH:       prdata = {21'd0, cfg_reg.frame_width};
            default:                        prdata = 32'd0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign wr_fire  = (state_reg == S_WRITE) && (!out_valid_reg || out_ready);

    hcm_pixel u_pixel
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .blue  (blue),
        .green (green),
        .red   (red),
        .cfg   (cfg_reg),
        .done  (pix_done),
        .bits  (pix_bits)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_CALC;
            S_CALC:  if (pix_done) state_next = S_WRITE;
            S_WRITE: if (wr_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cfg_reg.frame_width == 11'd0)
            width_eff = WW'(1);
        else if (32'(cfg_reg.frame_width) > 32'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(cfg_reg.frame_width);
        x_inc = {1'b0, col_reg} + WW'(1);

        draining = (phase_reg == hcm_pkg::PHASE_DRAIN);
        ignore   = 1'b0;
        phase_w  = phase_reg;
        fc_next  = fc_reg;
        if (!draining && (op_reg == hcm_pkg::OP_FLUSH))
        begin
            ignore   = (phase_reg == hcm_pkg::PHASE_FIRST) || (col_reg != '0);
            pending  = (phase_reg == hcm_pkg::PHASE_LATER);
            phase_w  = hcm_pkg::PHASE_DRAIN;
            draining = 1'b1;
            fc_next  = 1'b0;
        end
        else
        begin
            pending = draining ? fc_reg : (phase_reg == hcm_pkg::PHASE_LATER);
        end

        p   = draining ? 3'b000 : pix_bits;
        top = rd_reg[2:0];
        mid = rd_reg[5:3];
        bot = draining ? mid : p;
        col = {bot, mid, top};
        wb  = window_reg[17:9];
        wc  = window_reg[26:18];

        mem_we      = wr_fire && !ignore;
        mem_wdata   = {bot, mid};
        window_next = window_reg;
        emit        = 1'b0;
        emit_bits   = 3'b000;
        emit_eof    = 1'b0;
        last        = 1'b0;
        phase_next  = phase_w;
        col_next    = col_reg;

        if (phase_reg == hcm_pkg::PHASE_FIRST)
        begin
            mem_wdata = {p, p};
        end
        else if (col_reg == '0)
        begin
            if (pending)
            begin
                last      = draining && fc_reg;
                emit      = 1'b1;
                emit_bits = hcm_pkg::vote(wb, wc, wc);
                emit_eof  = last;
            end
            window_next = {col, col, col};
        end
        else
        begin
            window_next = {col, wc, wb};
            emit        = 1'b1;
            emit_bits   = hcm_pkg::vote(wb, wc, col);
        end

        if (last)
        begin
            window_next = '0;
            col_next    = '0;
            phase_next  = hcm_pkg::PHASE_FIRST;
            fc_next     = 1'b0;
        end
        else
        begin
            if (draining) fc_next = 1'b1;
            if (x_inc >= width_eff)
            begin
                col_next = '0;
                if (phase_w == hcm_pkg::PHASE_FIRST) phase_next = hcm_pkg::PHASE_SECOND;
                else if (phase_w == hcm_pkg::PHASE_SECOND) phase_next = hcm_pkg::PHASE_LATER;
            end
            else
            begin
                col_next = x_inc[AW-1:0];
            end
        end
        if (ignore) emit = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) rd_reg <= line_mem[col_reg];
        if (mem_we) line_mem[col_reg] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) op_reg <= opcode;
        if (wr_fire && emit)
        begin
            out_bits_reg <= emit_bits;
            out_eof_reg  <= emit_eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= '0;
            col_reg       <= '0;
            phase_reg     <= hcm_pkg::PHASE_FIRST;
            fc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_fire && !ignore)
            begin
                window_reg <= window_next;
                col_reg    <= col_next;
                phase_reg  <= phase_next;
                fc_reg     <= fc_next;
            end
            if (wr_fire && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign blue_bit     = out_bits_reg[0];
    assign green_bit    = out_bits_reg[1];
    assign red_bit      = out_bits_reg[2];
    assign end_of_frame = out_eof_reg;

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CALC))
        else $error("accepted transaction did not start the dividers");

    a_write_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WRITE) && out_valid_reg && !out_ready) |=> (state_reg == S_WRITE))
        else $error("write-back overran a held result");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> pix_done)
        else $error("write-back before divider finished");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !in_ready)
        else $error("line store written outside write-back");

endmodule
